>>> src/rycc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared widths, types and fixed-point coefficients of the JFIF color
// converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

   // Pixel component width and number of components per pixel.
   localparam int PIX_W = 8;
   localparam int NUM_CH = 3;

   // Fraction bits of the fixed-point coefficients (legal range 10 to 24).
   localparam int COEF_FRAC_BITS = 16;

   // A coefficient holds a sign, two integer bits and the fraction.
   localparam int COEF_W = COEF_FRAC_BITS + 3;
   // Operands are the pixel components or a chroma minus 128, all signed.
   localparam int OPND_W = PIX_W + 1;
   localparam int PROD_W = OPND_W + COEF_W;
   // Three products and one offset need two more bits of headroom.
   localparam int ACC_W = PROD_W + 2;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // Direction codes of the configuration register.
   localparam logic DIR_RGB_TO_YCC = 1'b0;
   localparam logic DIR_YCC_TO_RGB = 1'b1;

   // Coefficients: the decimal ratio times 2^COEF_FRAC_BITS, rounded half up.
   localparam longint K_Y_R  = ((longint'(299) << COEF_FRAC_BITS) + 500) / 1000;
   localparam longint K_Y_G  = ((longint'(587) << COEF_FRAC_BITS) + 500) / 1000;
   localparam longint K_Y_B  = ((longint'(114) << COEF_FRAC_BITS) + 500) / 1000;
   localparam longint K_HALF = ((longint'(1) << COEF_FRAC_BITS) + 1) / 2;
   localparam longint K_CR_G = ((longint'(4187) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint K_CR_B = ((longint'(813) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint K_CB_R = ((longint'(1687) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint K_CB_G = ((longint'(3313) << COEF_FRAC_BITS) + 5000) / 10000;
   localparam longint K_R_CR = ((longint'(1402) << COEF_FRAC_BITS) + 500) / 1000;
   localparam longint K_G_CR = ((longint'(71414) << COEF_FRAC_BITS) + 50000) / 100000;
   localparam longint K_G_CB = ((longint'(34414) << COEF_FRAC_BITS) + 50000) / 100000;
   localparam longint K_B_CB = ((longint'(1772) << COEF_FRAC_BITS) + 500) / 1000;
   localparam longint K_ONE  = longint'(1) << COEF_FRAC_BITS;

   // Forward matrix: rows give Y, Cr, Cb from R, G, B.
   localparam coef_type FWD_COEF [NUM_CH][NUM_CH] = '{
      '{COEF_W'(K_Y_R),   COEF_W'(K_Y_G),   COEF_W'(K_Y_B)},
      '{COEF_W'(K_HALF),  COEF_W'(-K_CR_G), COEF_W'(-K_CR_B)},
      '{COEF_W'(-K_CB_R), COEF_W'(-K_CB_G), COEF_W'(K_HALF)}
   };

   // Inverse matrix: rows give R, G, B from Y, Cr-128, Cb-128.
   localparam coef_type INV_COEF [NUM_CH][NUM_CH] = '{
      '{COEF_W'(K_ONE), COEF_W'(K_R_CR),  COEF_W'(0)},
      '{COEF_W'(K_ONE), COEF_W'(-K_G_CR), COEF_W'(-K_G_CB)},
      '{COEF_W'(K_ONE), COEF_W'(0),       COEF_W'(K_B_CB)}
   };

   // Chroma midpoint, as an operand and as an accumulator offset.
   localparam opnd_type CHROMA_MID = OPND_W'(128);
   localparam acc_type CHROMA_OFFS = ACC_W'(longint'(128) << COEF_FRAC_BITS);

endpackage

`default_nettype wire

>>> src/rycc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_req_if
// Pixel input channel: valid/ready handshake and three 8-bit components.
// ----------------------------------------------------------------------------
interface rycc_req_if
   import rycc_pkg::*;
   ();

   logic      valid;
   logic      ready;
   pixel_type first_channel;
   pixel_type second_channel;
   pixel_type third_channel;

   modport source (
      output valid,
      output first_channel,
      output second_channel,
      output third_channel,
      input  ready
   );

   modport sink (
      input  valid,
      input  first_channel,
      input  second_channel,
      input  third_channel,
      output ready
   );

endinterface

`default_nettype wire

>>> src/rycc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rycc_rsp_if
// Pixel result channel: valid/ready handshake and three 8-bit components.
// ----------------------------------------------------------------------------
interface rycc_rsp_if
   import rycc_pkg::*;
   ();

   logic      valid;
   logic      ready;
   pixel_type out_first;
   pixel_type out_second;
   pixel_type out_third;

   modport source (
      output valid,
      output out_first,
      output out_second,
      output out_third,
      input  ready
   );

   modport sink (
      input  valid,
      input  out_first,
      input  out_second,
      input  out_third,
      output ready
   );

endinterface

`default_nettype wire

>>> src/rgb_ycbcr_color_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert
// Full-range JFIF color conversion between RGB and YCrCb, one pixel a beat.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock unless the pipeline is stalled and
// returns one result beat per pixel, in order. The four register
// stages are operand setup, the nine coefficient multipliers, the three
// row sums, and the floor/clamp output register; each stage holds its beat
// when the next one is full, so a stalled output fills the pipeline up to
// four beats before req_chan.ready drops. The direction is sampled with each
// beat and csr_wr_en should only be used while no beat is in flight.
module rgb_ycbcr_color_convert
   import rycc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data,
   rycc_req_if.sink    req_chan,
   rycc_rsp_if.source  rsp_chan
);

   // Floor a fixed-point sum to an integer and clamp it to 0..255.
   function automatic pixel_type floor_clamp(input acc_type acc);
      pixel_type res;
      if (acc[ACC_W-1]) begin
         res = '0;
      end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
         res = '1;
      end else begin
         res = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
      return res;
   endfunction

   logic direction_ff;

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic     s1_dir_ff, s2_dir_ff, s3_dir_ff;
   opnd_type s1_opnd_ff [NUM_CH];
   opnd_type s1_opnd_in [NUM_CH];
   prod_type s2_prod_ff [NUM_CH][NUM_CH];
   prod_type s2_prod_in [NUM_CH][NUM_CH];
   acc_type  s3_acc_ff  [NUM_CH];
   acc_type  s3_acc_in  [NUM_CH];
   pixel_type s4_pix_ff [NUM_CH];
   pixel_type s4_pix_in [NUM_CH];

   logic s1_en, s2_en, s3_en, s4_en;

   // Each stage loads when it is empty or its content moves on.
   assign s4_en = !s4_valid_ff || rsp_chan.ready;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   // Direction register.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_RGB_TO_YCC;
      end else if (csr_wr_en) begin
         direction_ff <= csr_wr_data;
      end
   end

   // Operand setup: inverse mode centers the two chroma components.
   always_comb begin
      s1_opnd_in[0] = opnd_type'({1'b0, req_chan.first_channel});
      s1_opnd_in[1] = opnd_type'({1'b0, req_chan.second_channel});
      s1_opnd_in[2] = opnd_type'({1'b0, req_chan.third_channel});
      if (direction_ff == DIR_YCC_TO_RGB) begin
         s1_opnd_in[1] = opnd_type'({1'b0, req_chan.second_channel}) - CHROMA_MID;
         s1_opnd_in[2] = opnd_type'({1'b0, req_chan.third_channel}) - CHROMA_MID;
      end
   end

   // Nine products of operand and matrix coefficient.
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (s1_dir_ff == DIR_YCC_TO_RGB) begin
               s2_prod_in[r][c] = PROD_W'(s1_opnd_ff[c]) * PROD_W'(INV_COEF[r][c]);
            end else begin
               s2_prod_in[r][c] = PROD_W'(s1_opnd_ff[c]) * PROD_W'(FWD_COEF[r][c]);
            end
         end
      end
   end

   // Row sums; forward chroma rows add the 128 offset.
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         s3_acc_in[r] = ACC_W'(s2_prod_ff[r][0]) + ACC_W'(s2_prod_ff[r][1])
                      + ACC_W'(s2_prod_ff[r][2]);
         if (s2_dir_ff == DIR_RGB_TO_YCC && r != 0) begin
            s3_acc_in[r] = s3_acc_in[r] + CHROMA_OFFS;
         end
      end
   end

   // Floor and clamp into the output register.
   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         s4_pix_in[r] = floor_clamp(s3_acc_ff[r]);
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_dir_ff  <= direction_ff;
         s1_opnd_ff <= s1_opnd_in;
      end
      if (s2_en) begin
         s2_dir_ff  <= s1_dir_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (s3_en) begin
         s3_dir_ff <= s2_dir_ff;
         s3_acc_ff <= s3_acc_in;
      end
      if (s4_en) begin
         s4_pix_ff <= s4_pix_in;
      end
   end

   assign rsp_chan.valid      = s4_valid_ff;
   assign rsp_chan.out_first  = s4_pix_ff[0];
   assign rsp_chan.out_second = s4_pix_ff[1];
   assign rsp_chan.out_third  = s4_pix_ff[2];

   // A forward-mode sum is never negative: luma and offset chroma stay >= 0.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_dir_ff == DIR_RGB_TO_YCC |->
         !s3_acc_ff[0][ACC_W-1] && !s3_acc_ff[1][ACC_W-1] && !s3_acc_ff[2][ACC_W-1])
      else $error("forward-mode row sum went negative");

   // A stalled product stage keeps its beat.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_en |=> s2_valid_ff && $stable(s2_dir_ff))
      else $error("product stage lost a stalled beat");

   // A full sum stage that advances always lands in the output register.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s4_en |=> s4_valid_ff)
      else $error("beat dropped between sum stage and output");

   // Nothing is offered on the result channel right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result beat offered after reset");

endmodule

`default_nettype wire

>>> test/rgb_ycbcr_color_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert_tb
// Self-checking bench for the JFIF RGB/YCrCb converter. A short table of
// directed pixels is followed by random phases in both directions. Every
// accepted pixel is predicted with fixed-point math of the bench's own (or typed
// in) and matched in order against the result beats. Input gaps, output stalls
// and two long output hold-offs are applied along the way.
// ----------------------------------------------------------------------------
module rgb_ycbcr_color_convert_tb;
   import rycc_pkg::*;

   // Bench timing and run limits.
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_PIXELS = 100;
   localparam int MAX_REPORTS = 10;

   // Receiver stall modes.
   localparam int RX_FLOW = 0;
   localparam int RX_LIGHT = 1;
   localparam int RX_HEAVY = 2;
   localparam int RX_PERIODIC = 3;

   // Coefficients: each decimal ratio scaled by 2^frac, rounded half up.
   localparam longint F_ONE = longint'(1) << COEF_FRAC_BITS;
   localparam longint C_Y_R = (299 * F_ONE + 500) / 1000;
   localparam longint C_Y_G = (587 * F_ONE + 500) / 1000;
   localparam longint C_Y_B = (114 * F_ONE + 500) / 1000;
   localparam longint C_HALF = (F_ONE + 1) / 2;
   localparam longint C_CR_G = (4187 * F_ONE + 5000) / 10000;
   localparam longint C_CR_B = (813 * F_ONE + 5000) / 10000;
   localparam longint C_CB_R = (1687 * F_ONE + 5000) / 10000;
   localparam longint C_CB_G = (3313 * F_ONE + 5000) / 10000;
   localparam longint C_R_CR = (1402 * F_ONE + 500) / 1000;
   localparam longint C_G_CR = (71414 * F_ONE + 50000) / 100000;
   localparam longint C_G_CB = (34414 * F_ONE + 50000) / 100000;
   localparam longint C_B_CB = (1772 * F_ONE + 500) / 1000;
   localparam longint C_MID = 128 * F_ONE;

   typedef struct packed {
      pixel_type ch0;
      pixel_type ch1;
      pixel_type ch2;
   } trio_type;

   typedef struct packed {
      logic     dir;
      trio_type px;
      logic     known;
      trio_type want;
   } vector_type;

   localparam trio_type NO_WANT = '0;
   localparam int DIRECTED_ROWS = 23;

   // Directed pixels: extremes, primaries, alternating bit patterns and clamps.
   // Expected values are typed in only where they are exact by inspection.
   vector_type directed_rows [DIRECTED_ROWS] = '{
      '{DIR_RGB_TO_YCC, '{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd128, 8'd128}},
      '{DIR_RGB_TO_YCC, '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd128, 8'd128}},
      '{DIR_RGB_TO_YCC, '{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{DIR_RGB_TO_YCC, '{8'd1, 8'd1, 8'd1}, 1'b1, '{8'd1, 8'd128, 8'd128}},
      '{DIR_RGB_TO_YCC, '{8'd255, 8'd0, 8'd0}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd0, 8'd255, 8'd0}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd0, 8'd0, 8'd255}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd255, 8'd255, 8'd0}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd0, 8'd255, 8'd255}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd255, 8'd0, 8'd255}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd170, 8'd85, 8'd51}, 1'b0, NO_WANT},
      '{DIR_RGB_TO_YCC, '{8'd85, 8'd170, 8'd204}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd0, 8'd128, 8'd128}, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{DIR_YCC_TO_RGB, '{8'd255, 8'd128, 8'd128}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{DIR_YCC_TO_RGB, '{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{DIR_YCC_TO_RGB, '{8'd0, 8'd0, 8'd0}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd255, 8'd255, 8'd255}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd0, 8'd255, 8'd0}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd255, 8'd0, 8'd255}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd128, 8'd255, 8'd0}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd128, 8'd0, 8'd255}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd16, 8'd240, 8'd16}, 1'b0, NO_WANT},
      '{DIR_YCC_TO_RGB, '{8'd235, 8'd16, 8'd240}, 1'b0, NO_WANT}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   rycc_req_if req_chan ();
   rycc_rsp_if rsp_chan ();

   // Bench-side copy of the direction register.
   logic active_dir = DIR_RGB_TO_YCC;
   // Converted pixels waiting for their result beat, oldest first.
   trio_type awaited_pixels [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit long_hold_req = 1'b0;

   rgb_ycbcr_color_convert u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Floor the accumulator to an integer and clamp it to 0..255.
   function automatic pixel_type floor_to_pixel(input longint acc);
      longint whole;
      if (acc < 0) begin
         return '0;
      end
      whole = acc >>> COEF_FRAC_BITS;
      return (whole > 255) ? pixel_type'(255) : pixel_type'(whole);
   endfunction

   // Converted pixel for the given direction.
   function automatic trio_type convert_pixel(input logic dir, input trio_type px);
      longint a;
      longint b;
      longint c;
      trio_type res;
      a = longint'(px.ch0);
      b = longint'(px.ch1);
      c = longint'(px.ch2);
      if (dir == DIR_RGB_TO_YCC) begin
         res.ch0 = floor_to_pixel(C_Y_R * a + C_Y_G * b + C_Y_B * c);
         res.ch1 = floor_to_pixel(C_HALF * a - C_CR_G * b - C_CR_B * c + C_MID);
         res.ch2 = floor_to_pixel(-C_CB_R * a - C_CB_G * b + C_HALF * c + C_MID);
      end else begin
         b = b - 128;
         c = c - 128;
         res.ch0 = floor_to_pixel(a * F_ONE + C_R_CR * b);
         res.ch1 = floor_to_pixel(a * F_ONE - C_G_CR * b - C_G_CB * c);
         res.ch2 = floor_to_pixel(a * F_ONE + C_B_CB * c);
      end
      return res;
   endfunction

   // Random component, leaning toward the two extremes.
   function automatic pixel_type random_level();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end
      return pixel_type'($urandom_range(0, 255));
   endfunction

   // Offer one pixel beat and hold it until accepted; valid stays high after.
   task automatic offer_pixel(input trio_type px, input logic known, input trio_type want);
      req_chan.valid <= 1'b1;
      req_chan.first_channel <= px.ch0;
      req_chan.second_channel <= px.ch1;
      req_chan.third_channel <= px.ch2;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      awaited_pixels.push_back(known ? want : convert_pixel(active_dir, px));
   endtask

   task automatic pause_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until the pipeline has emptied.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      csr_wr_en <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_dir = dir;
   endtask

   // One random phase in a fixed direction, sent in bursts.
   task automatic run_random_phase(input logic dir, input int count, input bit with_hold);
      int sent;
      int burst;
      bit no_gaps;
      trio_type px;
      drain_results();
      if (dir != active_dir) begin
         write_direction(dir);
      end
      no_gaps = with_hold || ($urandom_range(0, 3) == 0);
      if (with_hold) begin
         long_hold_req = 1'b1;
      end
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            px.ch0 = random_level();
            px.ch1 = random_level();
            px.ch2 = random_level();
            offer_pixel(px, 1'b0, NO_WANT);
            sent++;
         end
         if (!no_gaps && sent < count) begin
            pause_sender($urandom_range(1, 7));
         end
      end
   endtask

   // Receiver: stall pattern that changes mode now and then, plus long hold-offs.
   initial begin : receiver
      int mode;
      int left;
      rsp_chan.ready <= 1'b0;
      mode = RX_FLOW;
      left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_chan.ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clock);
            long_hold_req = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(RX_FLOW, RX_PERIODIC);
            left = $urandom_range(16, 96);
         end
         left--;
         case (mode)
            RX_FLOW: begin
               rsp_chan.ready <= 1'b1;
            end
            RX_LIGHT: begin
               rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            end
            RX_HEAVY: begin
               rsp_chan.ready <= ($urandom_range(0, 9) < 3);
            end
            default: begin
               rsp_chan.ready <= (left % 3 != 0);
            end
         endcase
      end
   end

   // Match each result beat against the oldest converted pixel.
   always @(posedge clock) begin : result_check
      trio_type got;
      trio_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.ch0 = rsp_chan.out_first;
         got.ch1 = rsp_chan.out_second;
         got.ch2 = rsp_chan.out_third;
         if (awaited_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected result beat %0d/%0d/%0d", got.ch0, got.ch1, got.ch2);
            end
         end else begin
            want = awaited_pixels.pop_front();
            if (got.ch0 !== want.ch0 || got.ch1 !== want.ch1 || got.ch2 !== want.ch2) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch (dir %0d): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     active_dir, want.ch0, want.ch1, want.ch2, got.ch0, got.ch1, got.ch2);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random phases, drain and verdict.
   initial begin : stimulus
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.first_channel <= '0;
      req_chan.second_channel <= '0;
      req_chan.third_channel <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].dir != active_dir) begin
            drain_results();
            write_direction(directed_rows[i].dir);
         end
         offer_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].want);
      end

      // Alternate direction every phase; two phases carry a long output hold-off.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         run_random_phase((p % 2 == 0) ? DIR_RGB_TO_YCC : DIR_YCC_TO_RGB, PHASE_PIXELS,
            (p == 2 || p == 5));
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
